// ===== hdl/rrts_pkg.sv =====
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 64;
    localparam int TASK_ID_W      = 6;
    localparam int COUNT_OUT_W    = 7;
    localparam int MIN_SWITCH     = 2;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_RUN    = 2'd1,
        ACT_SWITCH = 2'd2,
        ACT_SLEEP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_RUN_REJ   = 2'd2,
        ST_SLEEP_IGN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MARK_FREE  = 2'd0,
        MARK_ALLOC = 2'd1,
        MARK_RUN   = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_INC  = 2'd1,
        ALU_DEC  = 2'd2
    } t_alu_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_RUN,
        S_SWITCH,
        S_SLEEP,
        S_FIND,
        S_DEC_CNT,
        S_DEC_POS,
        S_SHIFT,
        S_SHIFT_WR,
        S_FIX_POS,
        S_JUMP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic [TASK_ID_W-1:0]     allocated_task;
        logic                     jump;
        logic [TASK_ID_W-1:0]     jump_task;
        logic [COUNT_OUT_W-1:0]   running_count;
    } t_result;

endpackage

// ===== hdl/rrts_alu.sv =====
module rrts_alu #(
    parameter int CW = 7
) (
    input  rrts_pkg::t_alu_op i_op,
    input  logic [CW-1:0]     i_a,
    input  logic [CW-1:0]     i_b,
    output logic [CW-1:0]     o_y,
    output logic              o_ge,
    output logic              o_eq
);

    always_comb begin
        case (i_op)
            rrts_pkg::ALU_INC: o_y = i_a + CW'(1);
            rrts_pkg::ALU_DEC: o_y = i_a - CW'(1);
            default:           o_y = i_a;
        endcase
    end

    assign o_ge = (o_y >= i_b);
    assign o_eq = (o_y == i_b);

endmodule

// ===== hdl/rrts_store.sv =====
module rrts_store #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int IW         = $clog2(TASK_SLOTS)
) (
    input  logic                           i_clk,
    input  logic                           i_slot_we,
    input  logic [IW-1:0]                  i_slot_waddr,
    input  logic [1:0]                     i_slot_wdata,
    input  logic [IW-1:0]                  i_slot_raddr,
    output logic [1:0]                     o_slot_rdata,
    input  logic                           i_list_we,
    input  logic [IW-1:0]                  i_list_waddr,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_list_wdata,
    input  logic [IW-1:0]                  i_list_raddr,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_list_rdata
);

    logic [1:0]                     r_slot_mem [TASK_SLOTS];
    logic [rrts_pkg::TASK_ID_W-1:0] r_list_mem [TASK_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_slot_we) begin
            r_slot_mem[i_slot_waddr] <= i_slot_wdata;
        end
        o_slot_rdata <= r_slot_mem[i_slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_list_we) begin
            r_list_mem[i_list_waddr] <= i_list_wdata;
        end
        o_list_rdata <= r_list_mem[i_list_raddr];
    end

endmodule

// ===== hdl/rrts_seq.sv =====
module rrts_seq #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int IW         = $clog2(TASK_SLOTS),
    parameter int CW         = $clog2(TASK_SLOTS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_task_id,
    output logic                           o_res_valid,
    input  logic                           i_res_free,
    output rrts_pkg::t_result              o_res,
    output logic                           o_slot_we,
    output logic [IW-1:0]                  o_slot_waddr,
    output logic [1:0]                     o_slot_wdata,
    output logic [IW-1:0]                  o_slot_raddr,
    input  logic [1:0]                     i_slot_rdata,
    output logic                           o_list_we,
    output logic [IW-1:0]                  o_list_waddr,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_list_wdata,
    output logic [IW-1:0]                  o_list_raddr,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_list_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

    rrts_pkg::t_state               r_state, n_state;
    logic [rrts_pkg::TASK_ID_W-1:0] r_tid, n_tid;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [IW-1:0]                  r_pos, n_pos;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_wascur, n_wascur;
    logic                           r_before, n_before;
    rrts_pkg::t_result              r_res, n_res;

    rrts_pkg::t_alu_op alu_op;
    logic [CW-1:0]     alu_a, alu_b, alu_y;
    logic              alu_ge, alu_eq;
    logic              tid_ok;
    logic [IW-1:0]     tid_idx;
    logic [IW-1:0]     new_pos;

    rrts_alu #(.CW(CW)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y),
        .o_ge (alu_ge),
        .o_eq (alu_eq)
    );

    assign tid_ok  = (32'(r_tid) < TASK_SLOTS);
    assign tid_idx = IW'(r_tid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrts_pkg::S_CLEAR;
            r_idx   <= '0;
            r_pos   <= '0;
            r_count <= CW'(1);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid    <= n_tid;
        r_wascur <= n_wascur;
        r_before <= n_before;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_tid    = r_tid;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_wascur = r_wascur;
        n_before = r_before;
        n_res    = r_res;
        new_pos  = r_pos;

        alu_op = rrts_pkg::ALU_PASS;
        alu_a  = CW'(r_idx);
        alu_b  = r_count;

        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_slot_we    = 1'b0;
        o_slot_waddr = r_idx;
        o_slot_wdata = rrts_pkg::MARK_FREE;
        o_slot_raddr = r_idx;
        o_list_we    = 1'b0;
        o_list_waddr = r_idx;
        o_list_wdata = '0;
        o_list_raddr = r_idx;

        case (r_state)
            rrts_pkg::S_CLEAR: begin
                o_slot_we    = 1'b1;
                o_slot_wdata = (r_idx == '0) ? rrts_pkg::MARK_RUN : rrts_pkg::MARK_FREE;
                o_list_we    = 1'b1;
                alu_op       = rrts_pkg::ALU_INC;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = rrts_pkg::S_IDLE;
                end else begin
                    n_idx = IW'(alu_y);
                end
            end
            rrts_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_slot_raddr = (rrts_pkg::t_action'(i_action) == rrts_pkg::ACT_ALLOC)
                               ? '0 : IW'(i_task_id);
                o_list_raddr = '0;
                if (i_in_valid) begin
                    n_tid    = i_task_id;
                    n_idx    = '0;
                    n_res    = '0;
                    case (rrts_pkg::t_action'(i_action))
                        rrts_pkg::ACT_ALLOC:  n_state = rrts_pkg::S_ALLOC;
                        rrts_pkg::ACT_RUN:    n_state = rrts_pkg::S_RUN;
                        rrts_pkg::ACT_SWITCH: n_state = rrts_pkg::S_SWITCH;
                        default:              n_state = rrts_pkg::S_SLEEP;
                    endcase
                end
            end
            rrts_pkg::S_ALLOC: begin
                alu_op = rrts_pkg::ALU_INC;
                if (i_slot_rdata == rrts_pkg::MARK_FREE) begin
                    o_slot_we                = 1'b1;
                    o_slot_wdata             = rrts_pkg::MARK_ALLOC;
                    n_res.allocated_task     = rrts_pkg::TASK_ID_W'(r_idx);
                    n_state                  = rrts_pkg::S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_res.status = rrts_pkg::ST_NO_FREE;
                    n_state      = rrts_pkg::S_DONE;
                end else begin
                    n_idx        = IW'(alu_y);
                    o_slot_raddr = IW'(alu_y);
                end
            end
            rrts_pkg::S_RUN: begin
                alu_op = rrts_pkg::ALU_INC;
                alu_a  = r_count;
                if (!tid_ok || i_slot_rdata == rrts_pkg::MARK_RUN ||
                    r_count == CW'(TASK_SLOTS)) begin
                    n_res.status = rrts_pkg::ST_RUN_REJ;
                end else begin
                    o_slot_we    = 1'b1;
                    o_slot_waddr = tid_idx;
                    o_slot_wdata = rrts_pkg::MARK_RUN;
                    o_list_we    = 1'b1;
                    o_list_waddr = IW'(r_count);
                    o_list_wdata = r_tid;
                    n_count      = alu_y;
                end
                n_state = rrts_pkg::S_DONE;
            end
            rrts_pkg::S_SWITCH: begin
                alu_op = rrts_pkg::ALU_INC;
                alu_a  = CW'(r_pos);
                if (r_count >= CW'(rrts_pkg::MIN_SWITCH)) begin
                    new_pos      = alu_ge ? '0 : IW'(alu_y);
                    n_pos        = new_pos;
                    o_list_raddr = new_pos;
                    n_state      = rrts_pkg::S_JUMP;
                end else begin
                    n_state = rrts_pkg::S_DONE;
                end
            end
            rrts_pkg::S_SLEEP: begin
                if (!tid_ok || i_slot_rdata != rrts_pkg::MARK_RUN) begin
                    n_res.status = rrts_pkg::ST_SLEEP_IGN;
                    n_state      = rrts_pkg::S_DONE;
                end else begin
                    o_slot_we    = 1'b1;
                    o_slot_waddr = tid_idx;
                    o_slot_wdata = rrts_pkg::MARK_ALLOC;
                    n_state      = rrts_pkg::S_FIND;
                end
            end
            rrts_pkg::S_FIND: begin
                alu_op = rrts_pkg::ALU_INC;
                if (i_list_rdata == r_tid) begin
                    n_wascur = (r_idx == r_pos);
                    n_before = (r_idx < r_pos);
                    n_state  = rrts_pkg::S_DEC_CNT;
                end else begin
                    n_idx        = IW'(alu_y);
                    o_list_raddr = IW'(alu_y);
                end
            end
            rrts_pkg::S_DEC_CNT: begin
                alu_op  = rrts_pkg::ALU_DEC;
                alu_a   = r_count;
                n_count = alu_y;
                n_state = rrts_pkg::S_DEC_POS;
            end
            rrts_pkg::S_DEC_POS: begin
                alu_op = rrts_pkg::ALU_DEC;
                alu_a  = CW'(r_pos);
                if (r_before) begin
                    n_pos = IW'(alu_y);
                end
                n_state = rrts_pkg::S_SHIFT;
            end
            rrts_pkg::S_SHIFT: begin
                // entry idx still inside the list when idx+1 <= count
                alu_op = rrts_pkg::ALU_INC;
                if (!alu_ge || alu_eq) begin
                    o_list_raddr = IW'(alu_y);
                    n_state      = rrts_pkg::S_SHIFT_WR;
                end else begin
                    n_state = rrts_pkg::S_FIX_POS;
                end
            end
            rrts_pkg::S_SHIFT_WR: begin
                alu_op       = rrts_pkg::ALU_INC;
                o_list_we    = 1'b1;
                o_list_wdata = i_list_rdata;
                n_idx        = IW'(alu_y);
                n_state      = rrts_pkg::S_SHIFT;
            end
            rrts_pkg::S_FIX_POS: begin
                alu_a        = CW'(r_pos);
                new_pos      = alu_ge ? '0 : r_pos;
                n_pos        = new_pos;
                o_list_raddr = new_pos;
                if (r_wascur && r_count != '0) begin
                    n_state = rrts_pkg::S_JUMP;
                end else begin
                    n_state = rrts_pkg::S_DONE;
                end
            end
            rrts_pkg::S_JUMP: begin
                n_res.jump      = 1'b1;
                n_res.jump_task = i_list_rdata;
                n_state         = rrts_pkg::S_DONE;
            end
            rrts_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = rrts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res               = r_res;
        o_res.running_count = rrts_pkg::COUNT_OUT_W'(r_count);
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TASK_SLOTS))
        else $error("run count above slot count");

    a_pos_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrts_pkg::S_IDLE) |-> (CW'(r_pos) < r_count || r_pos == '0))
        else $error("position outside run list");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    a_jump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.jump) |-> (r_count != '0))
        else $error("jump with empty run list");
`endif

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// channel  | valid       | ready       | word
// ---------+-------------+-------------+----------------------------------------------
// in       | i_in_valid  | o_in_ready  | i_action, i_task_id
// out      | o_out_valid | i_out_ready | o_status, o_allocated_task, o_jump,
//          |             |             | o_jump_task, o_running_count
//
// One word at a time through a sequencer around one increment/compare unit: alloc scans
// slots from the lowest up, switch adds a jump only with two or more running, and sleep
// searches the run list, shifts the entries after the task and adds a jump if it was current.
// o_in_ready is high in the cycle after a word moves to the output register.
// After reset a clearing pass over all TASK_SLOTS slots runs with o_in_ready low.
// A finished word waits in S_DONE while the output register is full and i_out_ready is low.
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_task_id,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_allocated_task,
    output logic                           o_jump,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_jump_task,
    output logic [rrts_pkg::COUNT_OUT_W-1:0] o_running_count
);

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic                           slot_we;
    logic [IW-1:0]                  slot_waddr, slot_raddr;
    logic [1:0]                     slot_wdata, slot_rdata;
    logic                           list_we;
    logic [IW-1:0]                  list_waddr, list_raddr;
    logic [rrts_pkg::TASK_ID_W-1:0] list_wdata, list_rdata;

    logic              res_valid, res_free;
    rrts_pkg::t_result res;
    rrts_pkg::t_result r_out;
    logic              r_out_valid;

    assign res_free = !r_out_valid || i_out_ready;

    rrts_seq #(.TASK_SLOTS(TASK_SLOTS), .IW(IW), .CW(CW)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_task_id    (i_task_id),
        .o_res_valid  (res_valid),
        .i_res_free   (res_free),
        .o_res        (res),
        .o_slot_we    (slot_we),
        .o_slot_waddr (slot_waddr),
        .o_slot_wdata (slot_wdata),
        .o_slot_raddr (slot_raddr),
        .i_slot_rdata (slot_rdata),
        .o_list_we    (list_we),
        .o_list_waddr (list_waddr),
        .o_list_wdata (list_wdata),
        .o_list_raddr (list_raddr),
        .i_list_rdata (list_rdata)
    );

    rrts_store #(.TASK_SLOTS(TASK_SLOTS), .IW(IW)) u_store (
        .i_clk        (i_clk),
        .i_slot_we    (slot_we),
        .i_slot_waddr (slot_waddr),
        .i_slot_wdata (slot_wdata),
        .i_slot_raddr (slot_raddr),
        .o_slot_rdata (slot_rdata),
        .i_list_we    (list_we),
        .i_list_waddr (list_waddr),
        .i_list_wdata (list_wdata),
        .i_list_raddr (list_raddr),
        .o_list_rdata (list_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_allocated_task = r_out.allocated_task;
    assign o_jump           = r_out.jump;
    assign o_jump_task      = r_out.jump_task;
    assign o_running_count  = r_out.running_count;

endmodule
